// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define FCT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fat16 table assertion failed");

// Checked at every edge, reset included.
`define FCT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("fat16 table assertion failed");

`endif

// File: sv/fct_pkg.sv
// Package for the FAT16 cluster table: operation, status and register codes,
// reset values and the memory request type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fct_pkg;

    localparam int DEF_MAX_CLUSTERS = 4096;

    localparam int VAL_W = 16;
    localparam int CFG_W = 13;
    localparam int ADDR_W = 16;

    localparam logic [1:0] OP_READ   = 2'd0;
    localparam logic [1:0] OP_WRITE  = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_FORMAT = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_NOFREE = 2'd2;

    localparam logic [0:0] REG_COUNT = 1'b0;
    localparam logic [0:0] REG_MEDIA = 1'b1;

    localparam logic [CFG_W-1:0] COUNT_RESET = 13'd4096;
    localparam logic [7:0]       MEDIA_RESET = 8'hF8;

    localparam logic [7:0]       RESERVED_HI = 8'hFF;
    localparam logic [VAL_W-1:0] ALL_ONES    = 16'hFFFF;
    localparam logic [VAL_W-1:0] FREE_MARK   = 16'h0000;
    localparam logic [ADDR_W-1:0] FIRST_DATA = 16'd2;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [VAL_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

endpackage

`default_nettype wire

// File: sv/fct_op_if.sv
// Request channel of the FAT16 cluster table: valid/ready plus operation fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface fct_op_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] cluster;
    logic [15:0] entry_value;

    modport source (output valid, operation, cluster, entry_value, input ready);
    modport sink (input valid, operation, cluster, entry_value, output ready);
endinterface

`default_nettype wire

// File: sv/fct_res_if.sv
// Response channel of the FAT16 cluster table: valid/ready plus result fields.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface fct_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] result_value;
    logic [1:0]  status;

    modport source (output valid, result_value, status, input ready);
    modport sink (input valid, result_value, status, output ready);
endinterface

`default_nettype wire

// File: sv/fct_table_mem.sv
// Table storage: one write port and one registered read port.
// Depends on fct_pkg for the request type.
`timescale 1ns / 1ps
`default_nettype none

module fct_table_mem
    import fct_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
)
(
    input  wire logic             clk,
    input  wire mem_req_t         req,
    output logic [VAL_W-1:0]      rdata
);

    localparam int AW = $clog2(MAX_CLUSTERS);

    logic [VAL_W-1:0] mem [MAX_CLUSTERS];
    logic [VAL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[AW-1:0]] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[AW-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/fct_ctrl.sv
// Sequencer of the FAT16 cluster table: decodes requests, runs the free scan
// and the clearing sweep, and holds the response register.
// Depends on fct_pkg, fct_op_if and fct_res_if.
`timescale 1ns / 1ps
`default_nettype none

module fct_ctrl
    import fct_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    fct_op_if.sink                 req,
    fct_res_if.source              rsp,
    input  wire logic [CFG_W-1:0]  cluster_count,
    input  wire logic [7:0]        media_byte,
    output mem_req_t               mem_req,
    input  wire logic [VAL_W-1:0]  mem_rdata
);

    localparam int AW = $clog2(MAX_CLUSTERS);
    localparam int PW = AW + 1;
    localparam logic [16:0]   LIMIT = 17'(MAX_CLUSTERS);
    localparam logic [PW-1:0] LAST  = PW'(MAX_CLUSTERS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [PW-1:0]    ptr_reg, ptr_next;
    logic             fmt_reg, fmt_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [VAL_W-1:0] rsp_value_reg, pend_value_reg;
    logic [1:0]       rsp_status_reg, pend_status_reg;

    logic [16:0]      used_n;
    logic [16:0]      count_ext;
    logic             in_range;
    logic             accept;
    logic             out_free;
    logic [PW-1:0]    ptr_inc;
    logic             have_res;
    logic [VAL_W-1:0] res_val;
    logic [1:0]       res_st;
    logic             load_out;

    assign count_ext = 17'(cluster_count);
    assign used_n    = (count_ext > LIMIT) ? LIMIT : count_ext;
    assign in_range  = {1'b0, req.cluster} < used_n;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !rsp_valid_reg || rsp.ready;
    assign ptr_inc   = ptr_reg + PW'(1);

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        fmt_next   = fmt_reg;
        mem_req    = '0;
        have_res   = 1'b0;
        res_val    = '0;
        res_st     = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (req.operation)
                        OP_READ:
                        begin
                            if (in_range)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = req.cluster;
                                state_next    = S_READ;
                            end
                            else
                            begin
                                have_res = 1'b1;
                                res_val  = ALL_ONES;
                                res_st   = ST_RANGE;
                            end
                        end
                        OP_WRITE:
                        begin
                            have_res = 1'b1;
                            if (in_range)
                            begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = req.cluster;
                                mem_req.wdata = req.entry_value;
                            end
                            else
                            begin
                                res_val = ALL_ONES;
                                res_st  = ST_RANGE;
                            end
                        end
                        OP_FIND:
                        begin
                            if (used_n > 17'(FIRST_DATA))
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = FIRST_DATA;
                                ptr_next      = PW'(FIRST_DATA);
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                have_res = 1'b1;
                                res_st   = ST_NOFREE;
                            end
                        end
                        OP_FORMAT:
                        begin
                            ptr_next   = '0;
                            fmt_next   = 1'b1;
                            state_next = S_CLEAR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                have_res = 1'b1;
                res_val  = mem_rdata;
            end
            S_SCAN:
            begin
                // Entry at ptr_reg is on the read port now
                if (mem_rdata == FREE_MARK)
                begin
                    have_res = 1'b1;
                    res_val  = 16'(ptr_reg);
                end
                else if (17'(ptr_inc) >= used_n)
                begin
                    have_res = 1'b1;
                    res_st   = ST_NOFREE;
                end
                else
                begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = 16'(ptr_inc);
                    ptr_next      = ptr_inc;
                end
            end
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = 16'(ptr_reg);
                if (ptr_reg == '0)
                begin
                    mem_req.wdata = {RESERVED_HI, media_byte};
                end
                else if (ptr_reg == PW'(1))
                begin
                    mem_req.wdata = ALL_ONES;
                end
                else
                begin
                    mem_req.wdata = FREE_MARK;
                end
                if (ptr_reg == LAST)
                begin
                    fmt_next = 1'b0;
                    // The sweep after reset gives no response
                    if (fmt_reg)
                    begin
                        have_res = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (have_res)
        begin
            state_next = out_free ? S_IDLE : S_RESP;
        end
    end

    assign load_out = out_free && (have_res || (state_reg == S_RESP));

    always_comb
    begin
        if (load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            ptr_reg       <= '0;
            fmt_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            fmt_reg       <= fmt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            rsp_value_reg  <= have_res ? res_val : pend_value_reg;
            rsp_status_reg <= have_res ? res_st : pend_status_reg;
        end
        // Park the result until the response register frees
        if (have_res && !out_free)
        begin
            pend_value_reg  <= res_val;
            pend_status_reg <= res_st;
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.status       = rsp_status_reg;

endmodule

`default_nettype wire

// File: sv/fat16_cluster_table_unit.sv
// FAT16 cluster table, top level: configuration registers, sequencer and table.
// Depends on fct_pkg, fct_op_if, fct_res_if, fct_ctrl and fct_table_mem.
//
// Requests arrive on req (operation, cluster, entry_value) and each gives one
// response on rsp (result_value, status), both valid/ready, a transfer on
// valid and ready high together. One request is in work at a time.
// Work between request transfer and response, with rsp free:
//   write or out-of-range access: response loaded in the accepting cycle
//   read: one access through the registered memory read port
//   find free: reads entries from cluster 2 upward, one entry a cycle
//   format: the clearing sweep writes all MAX_CLUSTERS entries, one a cycle
// A response waits in the output register while rsp stalls; the next request
// is taken meanwhile and its result is parked until the register frees.
// After reset the table is swept once (req.ready low)
// to the formatted state with media byte 0xF8; configuration writes are
// taken throughout. cfg_we writes cfg_data to register cfg_index
// (0 cluster_count, 1 media_byte) at the clock edge.
`timescale 1ns / 1ps
`default_nettype none

module fat16_cluster_table_unit
    import fct_pkg::*;
#(
    parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    fct_op_if.sink                req,
    fct_res_if.source             rsp,
    input  wire logic             cfg_we,
    input  wire logic [0:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] count_reg, count_next;
    logic [7:0]       media_reg, media_next;
    mem_req_t         mem_req;
    logic [VAL_W-1:0] mem_rdata;

    always_comb
    begin
        count_next = count_reg;
        media_next = media_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_COUNT: count_next = cfg_data;
                REG_MEDIA: media_next = cfg_data[7:0];
                default:   count_next = count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
            media_reg <= MEDIA_RESET;
        end
        else
        begin
            count_reg <= count_next;
            media_reg <= media_next;
        end
    end

    fct_ctrl #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .cluster_count (count_reg),
        .media_byte    (media_reg),
        .mem_req       (mem_req),
        .mem_rdata     (mem_rdata)
    );

    fct_table_mem #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

endmodule

`default_nettype wire

// File: sv/fct_checker.sv
// Port-level checker for the FAT16 cluster table, bound to the top level.
// Depends on fct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module fct_checker
    import fct_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [15:0] rsp_result_value,
    input wire logic [1:0]  rsp_status
);

    // The clearing sweep holds off requests right after reset
    `FCT_ASSERT_ALWAYS(a_sweep_after_reset, clk, $rose(rst_n) |-> !req_ready)

    // A transfer either blocks the request side or shows a response next cycle
    `FCT_ASSERT(a_accept_progress, clk, rst_n, (req_valid && req_ready) |=> (!req_ready || rsp_valid))

    `FCT_ASSERT(a_range_value, clk, rst_n, (rsp_valid && rsp_status == ST_RANGE) |-> (rsp_result_value == ALL_ONES))

    `FCT_ASSERT(a_nofree_value, clk, rst_n, (rsp_valid && rsp_status == ST_NOFREE) |-> (rsp_result_value == FREE_MARK))

    `FCT_ASSERT(a_rsp_hold, clk, rst_n, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_result_value) && $stable(rsp_status)))

endmodule

bind fat16_cluster_table_unit fct_checker u_fct_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_result_value (rsp.result_value),
    .rsp_status       (rsp.status)
);

`default_nettype wire
